/* hw/rtl/dmsa_pkg.sv */
// Shared constants and types of the data memory sub-word access core.
`timescale 1ns / 1ps

package dmsa_pkg;

    localparam int DEPTH_WORDS = 4096;
    localparam int IDX_W = (DEPTH_WORDS > 1) ? $clog2(DEPTH_WORDS) : 1;
    localparam int WIN_IDX_W = 24;

    localparam logic [31:0] WIN_BASE = 32'h2000_0000;
    localparam logic [31:0] WIN_END  = 32'h2400_0000;
    localparam logic [31:0] PORT_OUT = 32'h3000_0000;
    localparam logic [31:0] PORT_IN  = 32'h3000_0004;

    localparam logic [31:0] MASK_WORD = 32'hFFFF_FFFF;
    localparam logic [31:0] MASK_HALF = 32'h0000_FFFF;
    localparam logic [31:0] MASK_BYTE = 32'h0000_00FF;

    localparam logic       FUNC_READ  = 1'b0;
    localparam logic       FUNC_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAULT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        ACC_FAULT,
        ACC_RANGE,
        ACC_MEM,
        ACC_PUT,
        ACC_GET
    } acc_kind_t;

    typedef struct packed {
        logic        func;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [7:0]  in_char;
        logic        in_eof;
    } req_word_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        out_char_valid;
        logic [7:0]  out_char;
        logic        took_char;
        logic [1:0]  status;
    } rsp_word_t;

    typedef struct packed {
        acc_kind_t        kind;
        logic             write;
        logic [1:0]       size;
        logic [1:0]       lane;
        logic [IDX_W-1:0] idx;
        logic [31:0]      wdata;
        logic [7:0]       in_char;
        logic             in_eof;
    } dec_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [31:0]      wr_data;
    } store_req_t;

endpackage

/* hw/rtl/dmsa_decode.sv */
// Address decode: alignment, window, range and character port selection.
`timescale 1ns / 1ps

module dmsa_decode
    import dmsa_pkg::*;
(
    input  req_word_t req,
    output dec_t      dec
);

    logic                 size_bad;
    logic                 misalign;
    logic                 in_win;
    logic [31:0]          win_off;
    logic [WIN_IDX_W-1:0] off_idx;
    logic                 beyond;

    always_comb
    begin
        size_bad = (req.size != SIZE_BYTE) && (req.size != SIZE_HALF)
                   && (req.size != SIZE_WORD);
        misalign = ((req.size == SIZE_WORD) && (req.addr[1:0] != 2'b00))
                   || ((req.size == SIZE_HALF) && req.addr[0]);
        in_win   = (req.addr >= WIN_BASE) && (req.addr < WIN_END);
        win_off  = req.addr - WIN_BASE;
        off_idx  = win_off[WIN_IDX_W+1:2];
        beyond   = {1'b0, off_idx} >= (WIN_IDX_W+1)'(DEPTH_WORDS);

        dec.write   = req.func;
        dec.size    = req.size;
        dec.lane    = req.addr[1:0];
        dec.idx     = off_idx[IDX_W-1:0];
        dec.wdata   = req.wdata;
        dec.in_char = req.in_char;
        dec.in_eof  = req.in_eof;

        if (size_bad || misalign)
        begin
            dec.kind = ACC_FAULT;
        end
        else if (in_win)
        begin
            dec.kind = beyond ? ACC_RANGE : ACC_MEM;
        end
        else if ((req.func == FUNC_WRITE) && (req.addr == PORT_OUT))
        begin
            dec.kind = ACC_PUT;
        end
        else if ((req.func == FUNC_READ) && (req.addr == PORT_IN))
        begin
            dec.kind = ACC_GET;
        end
        else
        begin
            dec.kind = ACC_FAULT;
        end
    end

endmodule

/* hw/rtl/dmsa_lane.sv */
// Lane merge for sub-word writes, lane extract for reads, result build.
`timescale 1ns / 1ps

module dmsa_lane
    import dmsa_pkg::*;
(
    input  dec_t        op,
    input  logic [31:0] word,
    output rsp_word_t   rsp,
    output logic        wr_en,
    output logic [31:0] wr_word
);

    logic [31:0] lane_mask;
    logic [4:0]  shift;

    always_comb
    begin
        case (op.size)
            SIZE_WORD: lane_mask = MASK_WORD;
            SIZE_HALF: lane_mask = MASK_HALF;
            default:   lane_mask = MASK_BYTE;
        endcase
        shift   = {op.lane, 3'b000};
        wr_word = (word & ~(lane_mask << shift)) | ((op.wdata & lane_mask) << shift);
        wr_en   = (op.kind == ACC_MEM) && (op.write == FUNC_WRITE);

        rsp.rdata          = '0;
        rsp.out_char_valid = 1'b0;
        rsp.out_char       = '0;
        rsp.took_char      = 1'b0;
        rsp.status         = ST_OK;
        case (op.kind)
            ACC_MEM:
            begin
                if (op.write == FUNC_READ)
                begin
                    rsp.rdata = (word >> shift) & lane_mask;
                end
            end
            ACC_PUT:
            begin
                rsp.out_char_valid = 1'b1;
                rsp.out_char       = op.wdata[7:0];
            end
            ACC_GET:
            begin
                if (op.in_eof)
                begin
                    rsp.rdata = MASK_WORD;
                end
                else
                begin
                    rsp.rdata     = {24'd0, op.in_char};
                    rsp.took_char = 1'b1;
                end
            end
            ACC_RANGE: rsp.status = ST_RANGE;
            default:   rsp.status = ST_FAULT;
        endcase
    end

endmodule

/* hw/rtl/dmsa_store.sv */
// Data word store: synchronous memory with a clearing sweep after reset.
`timescale 1ns / 1ps

module dmsa_store
    import dmsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  store_req_t  sreq,
    output logic        ready,
    output logic [31:0] rd_data
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH_WORDS - 1);

    logic [31:0]      mem [DEPTH_WORDS];
    logic [31:0]      rd_data_reg;
    logic             clear_busy_reg;
    logic             clear_busy_next;
    logic [IDX_W-1:0] clear_idx_reg;
    logic [IDX_W-1:0] clear_idx_next;
    logic             mem_we;
    logic [IDX_W-1:0] mem_widx;
    logic [31:0]      mem_wdata;

    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_idx_next  = clear_idx_reg;
        if (clear_busy_reg)
        begin
            clear_idx_next = clear_idx_reg + 1'b1;
            if (clear_idx_reg == IDX_LAST)
            begin
                clear_busy_next = 1'b0;
            end
        end
        mem_we    = clear_busy_reg || sreq.wr_en;
        mem_widx  = clear_busy_reg ? clear_idx_reg : sreq.wr_idx;
        mem_wdata = clear_busy_reg ? 32'd0 : sreq.wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_idx_reg  <= '0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_idx_reg  <= clear_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_widx] <= mem_wdata;
        end
        if (sreq.rd_en)
        begin
            rd_data_reg <= mem[sreq.rd_idx];
        end
    end

    assign ready   = !clear_busy_reg;
    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/mmio_data_memory_subword_access_core.sv */
// Top level of the data memory sub-word access core.
// Usage:
//   req channel (req_valid / req_stall / req) carries one access word:
//   read or write of byte, halfword or word size at a byte address.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result
//   word per access, in order.
//   The data window at 0x20000000 maps to a word store with little-endian
//   lanes; 0x30000000 (write) emits a character, 0x30000004 (read) takes one.
// Timing:
//   A word accepted at edge T is read from the store at T, merged and
//   written back at T+1, and held on rsp from T+1, first taken at T+2.
//   One access every 2 cycles: the one-cycle store read comes before the
//   lane merge and write-back of the same word.
// Reset:
//   After rst_n releases, the store is cleared one word a cycle, 4096
//   cycles, while req_stall stays high.
// Receiver stall:
//   The result is held in the output register; one more access may be
//   taken and waits in stage 1, before its write-back, until that
//   register frees.
`timescale 1ns / 1ps

module mmio_data_memory_subword_access_core
    import dmsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    dec_t        dec;
    dec_t        op_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    rsp_word_t   rsp_reg;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        st_ready;
    logic [31:0] st_rd_data;
    store_req_t  st_req;
    rsp_word_t   lane_rsp;
    logic        lane_wr_en;
    logic [31:0] lane_wr_word;
    logic        accept;
    logic        out_free;
    logic        s1_done;

    dmsa_decode u_decode (
        .req (req),
        .dec (dec)
    );

    dmsa_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .sreq    (st_req),
        .ready   (st_ready),
        .rd_data (st_rd_data)
    );

    dmsa_lane u_lane (
        .op      (op_reg),
        .word    (st_rd_data),
        .rsp     (lane_rsp),
        .wr_en   (lane_wr_en),
        .wr_word (lane_wr_word)
    );

    always_comb
    begin
        req_stall = !st_ready || s1_valid_reg;
        accept    = req_valid && !req_stall;
        out_free  = !rsp_valid_reg || !rsp_stall;
        s1_done   = s1_valid_reg && out_free;

        st_req.rd_en   = accept;
        st_req.rd_idx  = dec.idx;
        st_req.wr_en   = s1_done && lane_wr_en;
        st_req.wr_idx  = op_reg.idx;
        st_req.wr_data = lane_wr_word;

        s1_valid_next  = accept || (s1_valid_reg && !s1_done);
        rsp_valid_next = s1_done || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= dec;
        end
        if (s1_done)
        begin
            rsp_reg <= lane_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word did not enter stage 1");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !st_ready |-> !accept)
        else $error("word accepted during store clear");

    a_write_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        st_req.wr_en |-> (s1_done && (op_reg.kind == ACC_MEM)))
        else $error("store written outside write-back");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != ST_OK)) |->
        ((rsp_reg.rdata == 32'd0) && !rsp_reg.out_char_valid && !rsp_reg.took_char))
        else $error("error result carries data or side effect");
`endif

endmodule

/* bench/dmsa_result_checker.sv */
// Result checker for the data memory sub-word access core: predicts each result word and compares.
`timescale 1ns / 1ps

module dmsa_result_checker
    import dmsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_word_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_word_t rsp,
    output int        fail_count,
    output int        pending,
    output int        words_checked,
    output int        store_hits,
    output int        port_hits,
    output int        rejects
);

    logic [31:0] mem_image [DEPTH_WORDS];
    rsp_word_t   due_results [$];

    initial
    begin
        foreach (mem_image[i])
            mem_image[i] = '0;
        fail_count    = 0;
        pending       = 0;
        words_checked = 0;
        store_hits    = 0;
        port_hits     = 0;
        rejects       = 0;
    end

    function automatic rsp_word_t resolve_access(input req_word_t a, output acc_kind_t kind);
        rsp_word_t   r;
        logic [31:0] off;
        logic [31:0] lane_mask;
        logic [31:0] cur;
        logic [4:0]  shift;
        r      = '0;
        r.status = ST_FAULT;
        kind   = ACC_FAULT;
        if (!(a.size inside {SIZE_BYTE, SIZE_HALF, SIZE_WORD}))
            return r;
        if ((a.size == SIZE_WORD && a.addr[1:0] != 2'b00) || (a.size == SIZE_HALF && a.addr[0]))
            return r;
        if (a.addr >= WIN_BASE && a.addr < WIN_END)
        begin
            off = a.addr - WIN_BASE;
            if (off[31:2] >= DEPTH_WORDS)
            begin
                r.status = ST_RANGE;
                kind     = ACC_RANGE;
                return r;
            end
            kind      = ACC_MEM;
            r.status  = ST_OK;
            shift     = {a.addr[1:0], 3'b000};
            lane_mask = (a.size == SIZE_WORD) ? MASK_WORD :
                        (a.size == SIZE_HALF) ? MASK_HALF : MASK_BYTE;
            cur       = mem_image[off[IDX_W+1:2]];
            if (a.func == FUNC_WRITE)
                mem_image[off[IDX_W+1:2]] = (cur & ~(lane_mask << shift)) |
                                            ((a.wdata & lane_mask) << shift);
            else
                r.rdata = (cur >> shift) & lane_mask;
            return r;
        end
        if (a.func == FUNC_WRITE && a.addr == PORT_OUT)
        begin
            kind             = ACC_PUT;
            r.status         = ST_OK;
            r.out_char_valid = 1'b1;
            r.out_char       = a.wdata[7:0];
            return r;
        end
        if (a.func == FUNC_READ && a.addr == PORT_IN)
        begin
            kind     = ACC_GET;
            r.status = ST_OK;
            if (a.in_eof)
                r.rdata = MASK_WORD;
            else
            begin
                r.rdata     = {24'b0, a.in_char};
                r.took_char = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", field, want, got);
            fail_count++;
        end
    endtask

    // inputs only move at the rising edge, so the falling edge sees what the next edge takes
    always @(negedge clk)
    begin : watch
        rsp_word_t want;
        acc_kind_t kind;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result word with no access outstanding: %h", rsp);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("rdata", want.rdata, rsp.rdata);
                    compare_field("out_char_valid", 32'(want.out_char_valid),
                                  32'(rsp.out_char_valid));
                    compare_field("out_char", 32'(want.out_char), 32'(rsp.out_char));
                    compare_field("took_char", 32'(want.took_char), 32'(rsp.took_char));
                    compare_field("status", 32'(want.status), 32'(rsp.status));
                    words_checked++;
                end
            end
            if (req_valid && !req_stall)
            begin
                due_results.push_back(resolve_access(req, kind));
                case (kind)
                    ACC_MEM:          store_hits++;
                    ACC_PUT, ACC_GET: port_hits++;
                    default:          rejects++;
                endcase
            end
            pending = due_results.size();
        end
    end

endmodule

/* bench/testbench.sv */
// Top of the bench for the data memory sub-word access core: stimulus, stall patterns, verdict.
`timescale 1ns / 1ps

module testbench;
    import dmsa_pkg::*;

    localparam int          ITEMS        = 1850;
    localparam int          IDLE_LIMIT   = 20000;
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [31:0] LAST_WORD    = WIN_BASE + 32'(4 * (DEPTH_WORDS - 1));
    localparam logic [31:0] PAST_DEPTH   = WIN_BASE + 32'(4 * DEPTH_WORDS);

    typedef enum int { STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC } stall_mode_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp;

    int fail_count;
    int pending;
    int words_checked;
    int store_hits;
    int port_hits;
    int rejects;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mmio_data_memory_subword_access_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    dmsa_result_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .store_hits    (store_hits),
        .port_hits     (port_hits),
        .rejects       (rejects)
    );

    function automatic req_word_t make_access(input logic func, input logic [1:0] size,
                                              input logic [31:0] addr, input logic [31:0] wdata,
                                              input logic [7:0] in_char, input logic in_eof);
        return req_word_t'({func, size, addr, wdata, in_char, in_eof});
    endfunction

    function automatic req_word_t random_access();
        req_word_t   a;
        int unsigned pick;
        logic [31:0] word_idx;
        a.func    = 1'($urandom_range(0, 1));
        a.size    = 2'($urandom_range(SIZE_BYTE, SIZE_WORD));
        a.wdata   = $urandom;
        a.in_char = 8'($urandom_range(0, 255));
        a.in_eof  = ($urandom_range(0, 3) == 0);
        pick      = $urandom_range(0, 99);
        if (pick < 68)
        begin
            // mostly a small hot set of words so reads find earlier writes
            if (pick < 60)
                word_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEPTH_WORDS - 1)
                                                       : $urandom_range(0, 15);
            else
                word_idx = $urandom_range(DEPTH_WORDS, 32'h00FF_FFFF);
            a.addr = WIN_BASE + {word_idx[29:0], 2'b00};
            if (a.size == SIZE_BYTE)
                a.addr[1:0] = 2'($urandom_range(0, 3));
            else if (a.size == SIZE_HALF)
                a.addr[1] = 1'($urandom_range(0, 1));
        end
        else if (pick < 80)
            a.addr = (a.func == FUNC_WRITE) ? PORT_OUT : PORT_IN;
        else if (pick < 86)
            a.addr = (a.func == FUNC_WRITE) ? PORT_IN : PORT_OUT;
        else if (pick < 92)
        begin
            word_idx = $urandom_range(0, 15);
            a.addr   = WIN_BASE + {word_idx[29:0], 2'b00};
            if ($urandom_range(0, 2) == 0)
                a.size = '1;
            else if ($urandom_range(0, 1) == 0)
            begin
                a.size    = SIZE_HALF;
                a.addr[0] = 1'b1;
                a.addr[1] = 1'($urandom_range(0, 1));
            end
            else
            begin
                a.size      = SIZE_WORD;
                a.addr[1:0] = 2'($urandom_range(1, 3));
            end
        end
        else
        begin
            a.addr = $urandom;
            a.size = 2'($urandom_range(0, 3));
        end
        return a;
    endfunction

    // called at a rising edge; returns at the edge that takes the word
    task automatic issue_access(input req_word_t w);
        req       <= w;
        req_valid <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (!req_stall)
                break;
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic hold_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : rsp_stall_gen
        stall_mode_t mode;
        int          left;
        int          tick;
        rsp_stall <= 1'b0;
        tick = 0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
            left = $urandom_range(20, 200);
            repeat (left)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    STALL_NONE:  rsp_stall <= 1'b0;
                    STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                    default:     rsp_stall <= (tick % 7 < 3);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(negedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle = 0;
            else
                idle++;
        end
        $display("no handshake for %0d cycles, giving up", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        req_word_t directed [$];
        int        sent;
        int        burst_left;
        int        gap;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        directed.push_back(make_access(FUNC_WRITE, SIZE_WORD, WIN_BASE, 32'hFFFF_FFFF, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_WRITE, SIZE_BYTE, WIN_BASE + 1, 32'hABCD_EF00, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_WRITE, SIZE_HALF, WIN_BASE + 2, 32'h1234_5A5A, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_WORD, WIN_BASE, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_BYTE, WIN_BASE + 3, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_HALF, WIN_BASE + 2, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_BYTE, WIN_BASE + 1, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_WRITE, SIZE_WORD, LAST_WORD, 32'hA5C3_0F96, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_HALF, LAST_WORD + 2, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_WRITE, SIZE_WORD, PAST_DEPTH, 32'hFFFF_FFFF, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_BYTE, WIN_END - 1, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_BYTE, WIN_END, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_BYTE, WIN_BASE - 1, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_WRITE, SIZE_BYTE, PORT_OUT, 32'hFFFF_FF41, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_WRITE, SIZE_WORD, PORT_OUT, 32'h0000_00FF, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_WRITE, SIZE_HALF, PORT_OUT, 32'h0000_1200, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_BYTE, PORT_IN, 32'h0, 8'hFF, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_WORD, PORT_IN, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_HALF, PORT_IN, 32'h0, 8'h5A, 1'b1));
        directed.push_back(make_access(FUNC_READ, SIZE_WORD, PORT_OUT, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_WRITE, SIZE_BYTE, PORT_IN, 32'h0000_0041, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_WORD, WIN_BASE + 2, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_WRITE, SIZE_HALF, WIN_BASE + 1, 32'hFFFF_FFFF, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, '1, WIN_BASE, 32'h0, 8'h00, 1'b0));
        directed.push_back(make_access(FUNC_READ, SIZE_BYTE, 32'hFFFF_FFFF, 32'h0, 8'h00, 1'b0));

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            issue_access(directed[i]);
        hold_until_drained();

        burst_left = $urandom_range(1, 60);
        for (sent = 0; sent < ITEMS; sent++)
        begin
            issue_access(random_access());
            if (sent % 400 == 399)
                hold_until_drained();
            else
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 60);
                    gap        = $urandom_range(0, 12);
                    if (gap != 0)
                    begin
                        req_valid <= 1'b0;
                        repeat (gap)
                            @(posedge clk);
                    end
                end
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d result words checked: %0d store accesses, %0d port accesses, %0d rejected",
                 words_checked, store_hits, port_hits, rejects);
        $display("accesses covered byte/half/word lanes, both character ports, range and fault cases");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
